/* rtl/bmr_pkg.sv */
package bmr_pkg;

  // Message layout.
  localparam int unsigned HdrBytes   = 12;
  localparam int unsigned ChunkStart = 8;
  localparam logic [7:0]  PosCmdEnd  = 8'd3;
  localparam logic [7:0]  PosFlasEnd = 8'd11;

  localparam logic [7:0] ChB = 8'h42;
  localparam logic [7:0] ChL = 8'h4c;
  localparam logic [7:0] ChO = 8'h4f;
  localparam logic [7:0] ChK = 8'h4b;
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChF = 8'h46;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChS = 8'h53;

  localparam logic [31:0] CrcPoly = 32'h82f6_3b78;
  localparam logic [31:0] CrcInit = 32'hffff_ffff;

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_READ = 2'd1,
    MODE_DONE = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    EV_STORED     = 4'd0,
    EV_CHUNK_BAD  = 4'd1,
    EV_ERASE      = 4'd2,
    EV_REBOOT     = 4'd3,
    EV_PROGRAM    = 4'd4,
    EV_PAGE_BAD   = 4'd5,
    EV_FLASH_OK   = 4'd6,
    EV_FLASH_FAIL = 4'd7,
    EV_READ_DATA  = 4'd8,
    EV_OVERLONG   = 4'd9
  } event_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BLO_CRC,
    ST_BLO_CHECK,
    ST_BLO_COPY,
    ST_PAGE_CRC,
    ST_PAGE_CHECK,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_position;
    logic [7:0] byte_value;
    logic [6:0] read_word_index;
    logic       flash_failed;
  } in_t;

  typedef struct packed {
    event_e      event_res;
    logic [3:0]  chunk_number;
    logic [31:0] flash_address;
    logic [63:0] read_data;
    logic        restart_reader;
  } out_t;

  // Builds a result beat; the restart flag follows from the event.
  function automatic out_t mk_result(event_e ev, logic [3:0] chunk, logic [31:0] addr,
                                     logic [63:0] data);
    out_t r;
    r.event_res      = ev;
    r.chunk_number   = chunk;
    r.flash_address  = addr;
    r.read_data      = data;
    r.restart_reader = (ev == EV_STORED) || (ev == EV_CHUNK_BAD) || (ev == EV_ERASE) ||
                       (ev == EV_PROGRAM) || (ev == EV_PAGE_BAD) || (ev == EV_OVERLONG);
    return r;
  endfunction

endpackage

/* rtl/bmr_crc.sv */
module bmr_crc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        init_i,
  input  logic        en_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);
  import bmr_pkg::*;

  logic [31:0] crc_q, crc_d, step;

  // Reflected CRC-32C, one byte per cycle while en_i is high.
  always_comb begin
    step = crc_q ^ {24'd0, data_i};
    for (int k = 0; k < 8; k++) begin
      step = step[0] ? ((step >> 1) ^ CrcPoly) : (step >> 1);
    end
    crc_d = crc_q;
    if (init_i) begin
      crc_d = CrcInit;
    end else if (en_i) begin
      crc_d = step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

/* rtl/bootloader_message_receiver_core.sv */
// Bootloader message receiver: CRC-32C checked firmware chunk loader.
// The input channel (in_valid_i / in_ready_o / in_i) carries one beat per
// received message byte, page word read, or flash outcome. The output channel
// (out_valid_o / out_ready_i / out_o) carries at most one result beat per item.
// The sequencer handles one item at a time and in_ready_o is high only while
// it is idle. A BLO message ends with a CRC pass over the chunk in the message
// memory and, when the CRC matches, a copy pass into the page, and a FLAS
// message walks the page through the shared CRC unit one byte a cycle. There
// is a single CRC unit and one read port on each memory.
// Results sit in an output register; if the receiver stalls, the block still
// accepts the next item and only waits before staging another result.
// At reset the page reads as all zero through per-word valid bits, so no
// clearing pass is needed; clearing the page later also just resets those bits.
// The message memory is not cleared and holds whatever was last written.
module bootloader_message_receiver_core #(
  parameter int unsigned CHUNK_BYTES   = 64,
  parameter int unsigned MESSAGE_BYTES = 72,
  parameter int unsigned PAGE_BYTES    = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bmr_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bmr_pkg::out_t out_o
);
  import bmr_pkg::*;

  localparam int unsigned NumChunks  = PAGE_BYTES / CHUNK_BYTES;
  localparam int unsigned PageWords  = PAGE_BYTES / 8;
  localparam int unsigned ChunkWords = CHUNK_BYTES / 8;
  localparam int unsigned MsgAw      = $clog2(MESSAGE_BYTES);
  localparam int unsigned PageAw     = $clog2(PageWords);
  localparam int unsigned CntW       = $clog2(PAGE_BYTES + 1);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, pcnt;
  in_t item_q;
  logic [31:0] base_q;
  logic awaiting_q, awaiting_d;
  logic [7:0] hdr_q [HdrBytes];
  out_t res_q, res_d, out_q;
  logic out_valid_q;
  logic [55:0] wbuf_q, wbuf_d;

  logic accept, msg_we, proc, out_free;
  logic [7:0] msg_mem [MESSAGE_BYTES];
  logic [MsgAw-1:0] msg_raddr;
  logic [7:0] msg_rdata_q;

  logic [63:0] page_mem [PageWords];
  logic [PageWords-1:0] pvalid_q;
  logic [PageAw-1:0] page_raddr, page_waddr;
  logic [63:0] page_rdata_q, page_wdata, page_word;
  logic page_rvalid_q, page_we, page_clear;

  logic crc_init, crc_en;
  logic [7:0] crc_byte;
  logic [31:0] crc_val, crc_fin, be_crc, be_want;

  logic overlong, is_last, head_blo, head_kill, head_boot, head_flas, slot_ok, widx_ok;
  logic [7:0] slot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign msg_we     = accept && (in_i.mode == MODE_BYTE) && !awaiting_q &&
                      (32'(in_i.byte_position) < MESSAGE_BYTES);
  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = (cnt_q != '0);
  assign pcnt       = cnt_q - CntW'(1);

  // Decode of the captured header bytes.
  assign overlong  = (32'(item_q.byte_position) >= MESSAGE_BYTES);
  assign is_last   = (32'(item_q.byte_position) == MESSAGE_BYTES - 1);
  assign head_blo  = (hdr_q[0] == ChB) && (hdr_q[1] == ChL) && (hdr_q[2] == ChO);
  assign head_kill = (hdr_q[0] == ChK) && (hdr_q[1] == ChI) && (hdr_q[2] == ChL) &&
                     (hdr_q[3] == ChL);
  assign head_boot = (hdr_q[0] == ChB) && (hdr_q[1] == ChO) && (hdr_q[2] == ChO) &&
                     (hdr_q[3] == ChT);
  assign head_flas = (hdr_q[0] == ChF) && (hdr_q[1] == ChL) && (hdr_q[2] == ChA) &&
                     (hdr_q[3] == ChS);
  assign slot      = hdr_q[3];
  assign slot_ok   = (32'(slot) < NumChunks);
  assign widx_ok   = (32'(item_q.read_word_index) < PageWords);
  assign be_crc    = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
  assign be_want   = {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
  assign crc_fin   = ~crc_val;
  assign page_word = page_rvalid_q ? page_rdata_q : 64'd0;

  bmr_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (crc_init),
    .en_i   (crc_en),
    .data_i (crc_byte),
    .crc_o  (crc_val)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.mode)
            MODE_BYTE: state_d = awaiting_q ? ST_IDLE : ST_DECODE;
            MODE_READ: state_d = ST_READ;
            MODE_DONE: state_d = awaiting_q ? ST_EMIT : ST_IDLE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_DECODE: begin
        if (overlong) begin
          state_d = ST_EMIT;
        end else if (is_last && head_blo) begin
          state_d = slot_ok ? ST_BLO_CRC : ST_EMIT;
        end else if ((item_q.byte_position == PosCmdEnd) && (head_kill || head_boot)) begin
          state_d = ST_EMIT;
        end else if ((item_q.byte_position == PosFlasEnd) && head_flas) begin
          state_d = ST_PAGE_CRC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_BLO_CRC:    if (32'(cnt_q) == CHUNK_BYTES) state_d = ST_BLO_CHECK;
      ST_BLO_CHECK:  state_d = (crc_fin == be_crc) ? ST_BLO_COPY : ST_EMIT;
      ST_BLO_COPY:   if (32'(cnt_q) == CHUNK_BYTES) state_d = ST_EMIT;
      ST_PAGE_CRC:   if (32'(cnt_q) == PAGE_BYTES) state_d = ST_PAGE_CHECK;
      ST_PAGE_CHECK: state_d = ST_EMIT;
      ST_READ:       if (cnt_q == CntW'(1)) state_d = ST_EMIT;
      ST_EMIT:       if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Datapath control for each state.
  always_comb begin
    cnt_d      = cnt_q;
    res_d      = res_q;
    awaiting_d = awaiting_q;
    wbuf_d     = wbuf_q;
    crc_init   = 1'b0;
    crc_en     = 1'b0;
    crc_byte   = msg_rdata_q;
    msg_raddr  = '0;
    page_raddr = '0;
    page_we    = 1'b0;
    page_waddr = '0;
    page_wdata = {msg_rdata_q, wbuf_q};
    page_clear = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d    = '0;
        crc_init = 1'b1;
        if (accept && (in_i.mode == MODE_DONE) && awaiting_q) begin
          awaiting_d = 1'b0;
          page_clear = 1'b1;
          res_d = mk_result(in_i.flash_failed ? EV_FLASH_FAIL : EV_FLASH_OK, 4'd0, 32'd0,
                            64'd0);
        end
      end
      ST_DECODE: begin
        if (overlong) begin
          res_d = mk_result(EV_OVERLONG, 4'd0, 32'd0, 64'd0);
        end else if (is_last && head_blo && !slot_ok) begin
          res_d = mk_result(EV_CHUNK_BAD, slot[3:0], 32'd0, 64'd0);
        end else if (item_q.byte_position == PosCmdEnd) begin
          res_d = mk_result(head_kill ? EV_ERASE : EV_REBOOT, 4'd0, 32'd0, 64'd0);
        end
      end
      ST_BLO_CRC: begin
        if (32'(cnt_q) < CHUNK_BYTES) msg_raddr = MsgAw'(32'(cnt_q) + ChunkStart);
        crc_en = proc;
        cnt_d  = cnt_q + CntW'(1);
      end
      ST_BLO_CHECK: begin
        cnt_d = '0;
        res_d = mk_result(EV_CHUNK_BAD, slot[3:0], 32'd0, 64'd0);
      end
      ST_BLO_COPY: begin
        if (32'(cnt_q) < CHUNK_BYTES) msg_raddr = MsgAw'(32'(cnt_q) + ChunkStart);
        cnt_d = cnt_q + CntW'(1);
        if (proc) begin
          wbuf_d = {msg_rdata_q, wbuf_q[55:8]};
          if (pcnt[2:0] == 3'd7) begin
            page_we    = 1'b1;
            page_waddr = PageAw'(32'(slot) * ChunkWords + 32'(pcnt >> 3));
          end
        end
        res_d = mk_result(EV_STORED, slot[3:0], 32'd0, 64'd0);
      end
      ST_PAGE_CRC: begin
        page_raddr = PageAw'(cnt_q >> 3);
        crc_en     = proc;
        crc_byte   = page_word[8*pcnt[2:0] +: 8];
        cnt_d      = cnt_q + CntW'(1);
      end
      ST_PAGE_CHECK: begin
        if (crc_fin != be_want) begin
          page_clear = 1'b1;
          res_d = mk_result(EV_PAGE_BAD, 4'd0, 32'd0, 64'd0);
        end else begin
          awaiting_d = 1'b1;
          res_d = mk_result(EV_PROGRAM, 4'd0, base_q + be_crc, 64'd0);
        end
      end
      ST_READ: begin
        page_raddr = PageAw'(32'(item_q.read_word_index));
        cnt_d      = cnt_q + CntW'(1);
        res_d = mk_result(EV_READ_DATA, 4'd0, 32'd0, widx_ok ? page_word : 64'd0);
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      awaiting_q  <= 1'b0;
      base_q      <= 32'd0;
      out_valid_q <= 1'b0;
      pvalid_q    <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      awaiting_q <= awaiting_d;
      if (cfg_we_i) base_q <= cfg_data_i;
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (page_clear) begin
        pvalid_q <= '0;
      end else if (page_we) begin
        pvalid_q[page_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_i;
    res_q  <= res_d;
    wbuf_q <= wbuf_d;
    if ((state_q == ST_EMIT) && out_free) out_q <= res_q;
    if (msg_we && (32'(in_i.byte_position) < HdrBytes)) begin
      hdr_q[4'(in_i.byte_position)] <= in_i.byte_value;
    end
  end

  // Message memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (msg_we) msg_mem[MsgAw'(in_i.byte_position)] <= in_i.byte_value;
    msg_rdata_q <= msg_mem[msg_raddr];
  end

  // Page memory: one write port, one registered read port with valid bit.
  always_ff @(posedge clk_i) begin
    if (page_we) page_mem[page_waddr] <= page_wdata;
    page_rdata_q  <= page_mem[page_raddr];
    page_rvalid_q <= pvalid_q[page_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_page_write_only_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_we |-> (state_q == ST_BLO_COPY) && !awaiting_q)
    else $error("page written outside chunk copy");

  a_await_starts_with_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(awaiting_q) |-> (state_q == ST_EMIT) && (res_q.event_res == EV_PROGRAM))
    else $error("awaiting flash set without a program request");

  a_no_page_check_while_awaiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAGE_CRC) |-> !awaiting_q)
    else $error("page check while flash programming is pending");

endmodule
